/* src/growable_slot_allocator_top_defines.svh */
// Assertion macros for the slot allocator.
`ifndef GROWABLE_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define GROWABLE_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slot allocator assertion failed");
`define GSA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slot allocator assertion failed");
`else
`define GSA_ASSERT_IMP(lbl, ante, cons)
`define GSA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* src/gsa_pkg.sv */
// Types, constants and helpers for the slot allocator.
package gsa_pkg;

  localparam int unsigned MaxSlots     = 256;
  localparam int unsigned InitialSlots = 8;
  localparam int unsigned FieldSlots   = 256;
  localparam int unsigned EffMax  = (MaxSlots < FieldSlots) ? MaxSlots : FieldSlots;
  localparam int unsigned EffInit = (InitialSlots < EffMax) ? InitialSlots : EffMax;

  localparam int unsigned SlotW    = 8;
  localparam int unsigned CountW   = 9;
  localparam int unsigned WordW    = 16;
  localparam int unsigned NumWords = FieldSlots / WordW;
  localparam int unsigned BitIdxW  = $clog2(WordW);
  localparam int unsigned WordIdxW = $clog2(NumWords);

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MAXED      = 2'd1,
    ST_BAD_INDEX  = 2'd2,
    ST_NOT_IN_USE = 2'd3
  } status_e;

  typedef enum logic {
    KIND_LEASE  = 1'b0,
    KIND_RETURN = 1'b1
  } kind_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Lowest zero bit of a 16-bit word: first the nibble, then the bit in it.
  function automatic logic [3:0] ffz16(input logic [15:0] w);
    logic [3:0] nib_zero;
    logic [1:0] ni;
    logic [1:0] bi;
    logic [3:0] nib;
    nib_zero = '0;
    ni = '0;
    bi = '0;
    for (int n = 0; n < 4; n++) begin
      nib_zero[n] = ~&w[n*4 +: 4];
    end
    for (int n = 3; n >= 0; n--) begin
      if (nib_zero[n]) begin
        ni = 2'(n);
      end
    end
    nib = w[{ni, 2'b00} +: 4];
    for (int b = 3; b >= 0; b--) begin
      if (!nib[b]) begin
        bi = 2'(b);
      end
    end
    return {ni, bi};
  endfunction

endpackage

/* src/gsa_chan_if.sv */
// Request and response channel interfaces of the slot allocator.
interface gsa_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] slot;

  modport source (output valid, output kind, output slot, input ready);
  modport sink   (input valid, input kind, input slot, output ready);
endinterface

interface gsa_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] slot_id;
  logic [1:0] status;
  logic [8:0] pool_count;

  modport source (output valid, output slot_id, output status, output pool_count,
                  input ready);
  modport sink   (input valid, input slot_id, input status, input pool_count,
                  output ready);
endinterface

/* src/growable_slot_allocator_top.sv */
// Top level of the growable first-fit slot allocator.
//
// req_i carries requests: kind 0 leases the lowest free slot, kind 1 returns
// the slot given in slot. rsp_o carries one result per request: slot_id,
// status (ok, maxed_out, bad_index, not_in_use) and the pool count after it.
// Both channels transfer on valid and ready high at a rising clock edge.
//
// The in-use map sits in a 16 x 16-bit memory with a registered read;
// a per-word full flag picks the word a lease reads. A request is accepted
// in the idle state, where the word read is issued; the exec state then finds
// the bit, writes the word back and loads the result register, holding while
// an earlier result still waits. A new request is taken only after the exec
// state ends, since the read-modify-write of the map word must finish first.
//
// Reset clears the per-word valid and full flags at once, so every slot reads
// free and the pool count is 8; no clearing pass is needed.
// If the receiver stalls, a new request is still taken while the last result
// waits; its update then holds until the result register frees up.
module growable_slot_allocator_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  gsa_req_if.sink        req_i,
  gsa_rsp_if.source      rsp_o
);

  `include "growable_slot_allocator_top_defines.svh"

  localparam int unsigned SlotW    = gsa_pkg::SlotW;
  localparam int unsigned CountW   = gsa_pkg::CountW;
  localparam int unsigned WordW    = gsa_pkg::WordW;
  localparam int unsigned NumWords = gsa_pkg::NumWords;
  localparam int unsigned BitIdxW  = gsa_pkg::BitIdxW;
  localparam int unsigned WordIdxW = gsa_pkg::WordIdxW;

  gsa_pkg::state_e state_q, state_d;

  logic [CountW-1:0]   count_q, count_d;
  logic [NumWords-1:0] word_vld_q, word_vld_d;
  logic [NumWords-1:0] word_full_q, word_full_d;

  // request captured at transfer
  logic                kind_q;
  logic [SlotW-1:0]    slot_q;
  logic [WordIdxW-1:0] word_q;
  logic                any_free_q;

  // map memory
  logic [WordW-1:0]    mem_q [NumWords];
  logic [WordW-1:0]    rdata_q;
  logic                rd_vld_q;
  logic                mem_we;
  logic [WordW-1:0]    mem_wdata;

  // result register
  logic                out_vld_q, out_vld_d;
  logic [SlotW-1:0]    out_id_q, out_id_d;
  gsa_pkg::status_e    out_st_q, out_st_d;
  logic [CountW-1:0]   out_cnt_q, out_cnt_d;

  logic                req_xfer;
  logic                rsp_xfer;
  logic [WordIdxW-1:0] lease_word;
  logic [WordIdxW-1:0] rd_addr;
  logic                load;
  logic [WordW-1:0]    cur_word;
  logic [BitIdxW-1:0]  free_bit;
  logic [SlotW-1:0]    lease_idx;
  logic [WordW-1:0]    ret_mask;

  assign req_i.ready = (state_q == gsa_pkg::S_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign rsp_xfer    = out_vld_q && rsp_o.ready;

  assign lease_word = WordIdxW'(gsa_pkg::ffz16(word_full_q));
  assign rd_addr    = (req_i.kind == gsa_pkg::KIND_LEASE) ? lease_word
                                                          : req_i.slot[SlotW-1 -: WordIdxW];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[word_q] <= mem_wdata;
    end
    if (req_xfer) begin
      rdata_q    <= mem_q[rd_addr];
      kind_q     <= req_i.kind;
      slot_q     <= req_i.slot;
      word_q     <= rd_addr;
      any_free_q <= ~&word_full_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (req_xfer) begin
      rd_vld_q <= word_vld_q[rd_addr];
    end
  end

  // a word never written reads as all free
  assign cur_word  = rd_vld_q ? rdata_q : '0;
  assign free_bit  = BitIdxW'(gsa_pkg::ffz16(cur_word));
  assign lease_idx = {word_q, free_bit};
  assign ret_mask  = WordW'(1) << slot_q[BitIdxW-1:0];

  assign load = (state_q == gsa_pkg::S_EXEC) && (!out_vld_q || rsp_o.ready);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    word_vld_d  = word_vld_q;
    word_full_d = word_full_q;
    out_vld_d   = out_vld_q && !rsp_xfer;
    out_id_d    = out_id_q;
    out_st_d    = out_st_q;
    out_cnt_d   = out_cnt_q;
    mem_we      = 1'b0;
    mem_wdata   = cur_word;

    case (state_q)
      gsa_pkg::S_IDLE: begin
        if (req_xfer) begin
          state_d = gsa_pkg::S_EXEC;
        end
      end
      gsa_pkg::S_EXEC: begin
        if (load) begin
          state_d   = gsa_pkg::S_IDLE;
          out_vld_d = 1'b1;
          out_id_d  = slot_q;
          out_st_d  = gsa_pkg::ST_OK;
          if (kind_q == gsa_pkg::KIND_LEASE) begin
            mem_wdata = cur_word | (WordW'(1) << free_bit);
            if (!any_free_q) begin
              out_st_d = gsa_pkg::ST_MAXED;
            end else if ({1'b0, lease_idx} < count_q) begin
              mem_we   = 1'b1;
              out_id_d = lease_idx;
            end else if (count_q < CountW'(gsa_pkg::EffMax)) begin
              // every slot below the count is leased: the lowest free is the new one
              mem_we   = 1'b1;
              out_id_d = lease_idx;
              count_d  = count_q + CountW'(1);
            end else begin
              out_st_d = gsa_pkg::ST_MAXED;
            end
          end else begin
            mem_wdata = cur_word & ~ret_mask;
            if ({1'b0, slot_q} >= count_q) begin
              out_st_d = gsa_pkg::ST_BAD_INDEX;
            end else if ((cur_word & ret_mask) == '0) begin
              out_st_d = gsa_pkg::ST_NOT_IN_USE;
            end else begin
              mem_we = 1'b1;
            end
          end
          if (mem_we) begin
            word_vld_d[word_q]  = 1'b1;
            word_full_d[word_q] = &mem_wdata;
          end
          out_cnt_d = count_d;
        end
      end
      default: begin
        state_d = gsa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gsa_pkg::S_IDLE;
      count_q     <= CountW'(gsa_pkg::EffInit);
      word_vld_q  <= '0;
      word_full_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      word_vld_q  <= word_vld_d;
      word_full_q <= word_full_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_id_q  <= out_id_d;
    out_st_q  <= out_st_d;
    out_cnt_q <= out_cnt_d;
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.slot_id    = out_id_q;
  assign rsp_o.status     = out_st_q;
  assign rsp_o.pool_count = out_cnt_q;

  `GSA_ASSERT_NXT(a_exec_after_xfer, req_xfer, state_q == gsa_pkg::S_EXEC)
  `GSA_ASSERT_IMP(a_count_step, count_q != $past(count_q), count_q == $past(count_q) + CountW'(1))
  `GSA_ASSERT_IMP(a_rsp_from_exec, $rose(out_vld_q), $past(state_q) == gsa_pkg::S_EXEC)
  `GSA_ASSERT_IMP(a_full_needs_vld, 1'b1, (word_full_q & ~word_vld_q) == '0)

endmodule

/* tb/growable_slot_allocator_checker.sv */
// Checker for the slot allocator: watches both channels, predicts and compares results.
module growable_slot_allocator_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  gsa_req_if                        req_i,
  gsa_rsp_if                        rsp_i,
  output int                        mismatch_count_o,
  output int                        pending_o,
  output int                        served_o,
  output int                        ok_o,
  output int                        maxed_o,
  output int                        bad_index_o,
  output int                        not_in_use_o,
  output logic [gsa_pkg::CountW-1:0] pool_count_o
);

  typedef struct packed {
    logic [gsa_pkg::SlotW-1:0]  slot_id;
    gsa_pkg::status_e           status;
    logic [gsa_pkg::CountW-1:0] pool_count;
  } alloc_result_t;

  logic [gsa_pkg::FieldSlots-1:0] slot_leased;
  logic [gsa_pkg::CountW-1:0]     slots_existing;
  alloc_result_t                  awaited_q[$];

  int mismatches;
  int pending;
  int served;
  int n_ok;
  int n_maxed;
  int n_bad_index;
  int n_not_in_use;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;
  assign served_o         = served;
  assign ok_o             = n_ok;
  assign maxed_o          = n_maxed;
  assign bad_index_o      = n_bad_index;
  assign not_in_use_o     = n_not_in_use;
  assign pool_count_o     = slots_existing;

  // Applies one request to the shadow pool and returns the result it must produce.
  function automatic alloc_result_t allocate(input gsa_pkg::kind_e kind,
                                             input logic [gsa_pkg::SlotW-1:0] slot);
    alloc_result_t r;
    bit            found;
    int            pick;
    r.slot_id = slot;
    r.status  = gsa_pkg::ST_OK;
    found     = 1'b0;
    pick      = 0;
    if (kind == gsa_pkg::KIND_LEASE) begin
      for (int i = 0; i < int'(slots_existing) && !found; i++) begin
        if (!slot_leased[i]) begin
          found = 1'b1;
          pick  = i;
        end
      end
      if (found) begin
        slot_leased[pick] = 1'b1;
        r.slot_id         = pick[gsa_pkg::SlotW-1:0];
      end else if (slots_existing >= gsa_pkg::EffMax) begin
        r.status = gsa_pkg::ST_MAXED;
      end else begin
        // every existing slot is leased: append one at index count
        slot_leased[slots_existing[gsa_pkg::SlotW-1:0]] = 1'b1;
        r.slot_id      = slots_existing[gsa_pkg::SlotW-1:0];
        slots_existing = slots_existing + 1'b1;
      end
    end else if (slot >= slots_existing) begin
      r.status = gsa_pkg::ST_BAD_INDEX;
    end else if (!slot_leased[slot]) begin
      r.status = gsa_pkg::ST_NOT_IN_USE;
    end else begin
      slot_leased[slot] = 1'b0;
    end
    r.pool_count = slots_existing;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      slot_leased    = '0;
      slots_existing = gsa_pkg::CountW'(gsa_pkg::EffInit);
      awaited_q.delete();
      pending        = 0;
      mismatches     = 0;
      served         = 0;
      n_ok           = 0;
      n_maxed        = 0;
      n_bad_index    = 0;
      n_not_in_use   = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        served++;
        case (gsa_pkg::status_e'(rsp_i.status))
          gsa_pkg::ST_OK:         n_ok++;
          gsa_pkg::ST_MAXED:      n_maxed++;
          gsa_pkg::ST_BAD_INDEX:  n_bad_index++;
          gsa_pkg::ST_NOT_IN_USE: n_not_in_use++;
          default:                ;
        endcase
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing awaited (slot_id %0d status %0d)",
                                    rsp_i.slot_id, rsp_i.status));
        end else begin
          want = awaited_q.pop_front();
          if (rsp_i.slot_id !== want.slot_id)
            report_mismatch($sformatf("result %0d slot_id %0d, want %0d",
                                      served, rsp_i.slot_id, want.slot_id));
          if (rsp_i.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d",
                                      served, rsp_i.status, want.status));
          if (rsp_i.pool_count !== want.pool_count)
            report_mismatch($sformatf("result %0d pool_count %0d, want %0d",
                                      served, rsp_i.pool_count, want.pool_count));
        end
      end
      if (req_i.valid && req_i.ready) begin
        awaited_q.push_back(allocate(gsa_pkg::kind_e'(req_i.kind), req_i.slot));
      end
      pending = awaited_q.size();
    end
  end

endmodule

/* tb/tb_growable_slot_allocator_top.sv */
// Testbench top for the slot allocator: clock, reset, request stimulus and verdict.
module tb_growable_slot_allocator_top;

  localparam int RandomPerPhase = 650;
  localparam int CycleLimit     = 200000;
  localparam int DrainCycles    = 20;

  logic clk_i = 1'b0;
  logic rst_ni;

  int snd_idle_pct;
  int rcv_idle_pct;
  int cycles;

  int                         mismatch_count;
  int                         pending;
  int                         served;
  int                         n_ok;
  int                         n_maxed;
  int                         n_bad_index;
  int                         n_not_in_use;
  logic [gsa_pkg::CountW-1:0] pool_count;
  logic [gsa_pkg::CountW-1:0] pool_hint;

  gsa_req_if req();
  gsa_rsp_if rsp();

  growable_slot_allocator_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  growable_slot_allocator_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req),
    .rsp_i            (rsp),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .served_o         (served),
    .ok_o             (n_ok),
    .maxed_o          (n_maxed),
    .bad_index_o      (n_bad_index),
    .not_in_use_o     (n_not_in_use),
    .pool_count_o     (pool_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver side: random stalls on the result channel
  always @(posedge clk_i) begin
    rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // pool size as last reported, used only to aim return requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_hint <= gsa_pkg::CountW'(gsa_pkg::EffInit);
    end else if (rsp.valid && rsp.ready) begin
      pool_hint <= rsp.pool_count;
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic send_request(input gsa_pkg::kind_e kind,
                              input logic [gsa_pkg::SlotW-1:0] slot);
    while ($urandom_range(99) < snd_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.kind  <= kind;
    req.slot  <= slot;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic send_random(input int lease_pct);
    int                        pick;
    logic [gsa_pkg::SlotW-1:0] slot;
    pick = $urandom_range(99);
    slot = gsa_pkg::SlotW'($urandom_range(255));
    if ($urandom_range(99) < lease_pct) begin
      send_request(gsa_pkg::KIND_LEASE, slot);
    end else begin
      // mostly existing slots; some just past the count, some anywhere
      if (pick < 85)
        slot = gsa_pkg::SlotW'($urandom_range(int'(pool_hint) - 1, 0));
      else if (pick < 92 && pool_hint < gsa_pkg::FieldSlots)
        slot = pool_hint[gsa_pkg::SlotW-1:0];
      send_request(gsa_pkg::KIND_RETURN, slot);
    end
  endtask

  // the last transfer lands in the checker at this edge; look from the next one
  task automatic drain_and_pause();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    rst_ni       <= 1'b0;
    req.valid    <= 1'b0;
    req.kind     <= gsa_pkg::KIND_LEASE;
    req.slot     <= '0;
    snd_idle_pct = 33;
    rcv_idle_pct = 79;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pool, out of range, fill, growth, free and reuse
    send_request(gsa_pkg::KIND_RETURN, 8'd0);
    send_request(gsa_pkg::KIND_RETURN, 8'd8);
    send_request(gsa_pkg::KIND_RETURN, 8'd255);
    for (int i = 0; i < 8; i++) begin
      send_request(gsa_pkg::KIND_LEASE, (i % 2 == 0) ? 8'hFF : 8'h00);
    end
    send_request(gsa_pkg::KIND_LEASE, 8'hAA);
    send_request(gsa_pkg::KIND_RETURN, 8'd9);
    send_request(gsa_pkg::KIND_RETURN, 8'd8);
    send_request(gsa_pkg::KIND_RETURN, 8'd8);
    send_request(gsa_pkg::KIND_RETURN, 8'd3);
    send_request(gsa_pkg::KIND_LEASE, 8'h55);
    send_request(gsa_pkg::KIND_LEASE, 8'h0F);
    send_request(gsa_pkg::KIND_LEASE, 8'hF0);
    send_request(gsa_pkg::KIND_RETURN, 8'd0);
    send_request(gsa_pkg::KIND_RETURN, 8'd7);
    send_request(gsa_pkg::KIND_LEASE, 8'h01);
    send_request(gsa_pkg::KIND_LEASE, 8'h80);

    // lease-heavy phase pushes the pool up to its maximum
    for (int i = 0; i < RandomPerPhase; i++) send_random(75);
    drain_and_pause();

    snd_idle_pct = 79;
    rcv_idle_pct = 33;
    for (int i = 0; i < RandomPerPhase; i++) send_random(45);
    drain_and_pause();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    for (int i = 0; i < RandomPerPhase; i++) send_random(60);
    drain_and_pause();

    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d results: %0d ok, %0d maxed_out, %0d bad_index, %0d not_in_use",
             served, n_ok, n_maxed, n_bad_index, n_not_in_use);
    $display("Pool ended at %0d slots; %0d mismatches", pool_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
